[rtl/lprl_pkg.sv]
// ----------------------------------------------------------------------------
// lprl_pkg: shared types and constants for the route lookup
// Table geometry, command codes, cell control structs and best-match merge.
// ----------------------------------------------------------------------------
`default_nettype none

package lprl_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam int NCELL       = 8;
	localparam int CELL_W      = $clog2(NCELL);
	localparam int SLICE       = TABLE_DEPTH / NCELL;
	localparam int ROW_W       = IDX_W - CELL_W;
	localparam int ADDR_W      = 32;
	localparam int PORT_W      = 8;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] prefix;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] hop;
		logic [PORT_W-1:0] port;
	} route_entry_t;

	typedef struct packed {
		logic              hit;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] hop;
		logic [PORT_W-1:0] port;
	} route_best_t;

	typedef struct packed {
		logic              we;
		logic [CELL_W-1:0] bank;
		logic [ROW_W-1:0]  row;
		route_entry_t      data;
	} entry_wr_t;

	typedef struct packed {
		logic              clear;
		logic              rd_en;
		logic [ROW_W-1:0]  rd_row;
		logic              cmp_en;
		logic [ROW_W-1:0]  cmp_row;
		logic [ADDR_W-1:0] addr;
		logic [CNT_W-1:0]  limit;
	} scan_ctl_t;

	// Keep prev unless cur hits and prev misses or cur has a strictly greater mask: earlier slot wins ties.
	function automatic route_best_t best_merge(route_best_t prev, route_best_t cur);
		route_best_t res;
		res = prev;
		if (cur.hit && (!prev.hit || (cur.mask > prev.mask))) begin
			res = cur;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

[rtl/lprl_if.sv]
// ----------------------------------------------------------------------------
// lprl_if: request and response channels
// Valid/ready channels carrying lookup/write requests and lookup results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lprl_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [9:0]  entry_index;
	logic [31:0] entry_prefix;
	logic [31:0] entry_mask;
	logic [31:0] entry_gateway;
	logic [7:0]  entry_port;
	logic [31:0] lookup_addr;

	modport source (
		output valid, cmd, entry_index, entry_prefix, entry_mask, entry_gateway,
		       entry_port, lookup_addr,
		input  ready
	);
	modport sink (
		input  valid, cmd, entry_index, entry_prefix, entry_mask, entry_gateway,
		       entry_port, lookup_addr,
		output ready
	);
endinterface

interface lprl_rsp_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [31:0] gateway;
	logic [7:0]  out_port;

	modport source (
		output valid, found, gateway, out_port,
		input  ready
	);
	modport sink (
		input  valid, found, gateway, out_port,
		output ready
	);
endinterface

`default_nettype wire

[rtl/longest_prefix_route_lookup.sv]
// A lookup item is taken only while idle; the row counter then steps one slice row
// per cycle over every slice at once (1024 entries over 8 cells), the cell chain
// settles in the drain state, and the result is loaded once the output register is free.
// No new item is taken until that result is loaded; a waiting result holds the input.
// A write item is taken every cycle while no lookup runs.
// Reset clears entry_count and control state; table contents undefined until written.
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup: linear-scan IPv4 longest prefix match
// Route table split over a row of cells; each cell scans its slice and the
// running best match moves along the chain to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_prefix_route_lookup
	import lprl_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_wdata,
	lprl_req_if.sink              req,
	lprl_rsp_if.source            rsp
);

	logic [CNT_W-1:0] entry_count_q;
	logic             req_fire;
	logic             start;
	logic             idle;
	logic             load;
	logic             out_busy;
	logic             out_valid_q;
	route_best_t      out_q;
	scan_ctl_t        ctl;
	entry_wr_t        wr;
	route_best_t      chain [NCELL+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	assign req.ready = idle;
	assign req_fire  = req.valid && req.ready;
	assign start     = req_fire && (req.cmd == CMD_LOOKUP);
	assign out_busy  = out_valid_q && !rsp.ready;

	always_comb begin
		wr.we          = req_fire && (req.cmd == CMD_WRITE);
		wr.bank        = req.entry_index[IDX_W-1:ROW_W];
		wr.row         = req.entry_index[ROW_W-1:0];
		wr.data.prefix = req.entry_prefix;
		wr.data.mask   = req.entry_mask;
		wr.data.hop    = req.entry_gateway;
		wr.data.port   = req.entry_port;
	end

	lprl_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.addr        (req.lookup_addr),
		.entry_count (entry_count_q),
		.out_busy    (out_busy),
		.idle        (idle),
		.load        (load),
		.ctl         (ctl)
	);

	assign chain[0] = '0;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		lprl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_id   (CELL_W'(k)),
			.wr        (wr),
			.ctl       (ctl),
			.chain_in  (chain[k]),
			.chain_out (chain[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= chain[NCELL];
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.found    = out_q.hit;
	assign rsp.gateway  = out_q.hop;
	assign rsp.out_port = out_q.port;

endmodule

`default_nettype wire

[rtl/lprl_cell.sv]
// ----------------------------------------------------------------------------
// lprl_cell: one slice of the route table
// Holds SLICE entries, scans them one per cycle keeping a local best, and
// merges its best into the running best handed along the chain every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lprl_cell
	import lprl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [CELL_W-1:0] cell_id,
	input  wire entry_wr_t         wr,
	input  wire scan_ctl_t         ctl,
	input  wire route_best_t       chain_in,
	output route_best_t            chain_out
);

	route_entry_t mem [SLICE];
	route_entry_t rd_s1;
	route_best_t  local_q;
	route_best_t  chain_q;
	route_best_t  cand;
	logic         in_range;

	always_ff @(posedge clk) begin
		if (wr.we && (wr.bank == cell_id)) begin
			mem[wr.row] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_s1 <= mem[ctl.rd_row];
		end
	end

	always_comb begin
		in_range  = CNT_W'({cell_id, ctl.cmp_row}) < ctl.limit;
		cand.hit  = ctl.cmp_en && in_range
		            && ((ctl.addr & rd_s1.mask) == rd_s1.prefix);
		cand.mask = rd_s1.mask;
		cand.hop  = rd_s1.hop;
		cand.port = rd_s1.port;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_q <= '0;
			chain_q <= '0;
		end else begin
			if (ctl.clear) begin
				local_q <= '0;
			end else begin
				local_q <= best_merge(local_q, cand);
			end
			// earlier cells come in from the left, so they take priority on ties
			chain_q <= best_merge(chain_in, local_q);
		end
	end

	assign chain_out = chain_q;

endmodule

`default_nettype wire

[rtl/lprl_ctrl.sv]
// ----------------------------------------------------------------------------
// lprl_ctrl: lookup sequencer
// Steps the row counter over the slices, then waits for the chain to settle
// and signals when the result may be loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module lprl_ctrl
	import lprl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [CNT_W-1:0]  entry_count,
	input  wire logic              out_busy,
	output logic                   idle,
	output logic                   load,
	output scan_ctl_t              ctl
);

	localparam int DRN_N = NCELL + 2;
	localparam int DRN_W = $clog2(DRN_N);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]        state_q;
	logic [ROW_W-1:0]  row_q;
	logic [DRN_W-1:0]  drain_q;
	logic              cmp_en_s1;
	logic [ROW_W-1:0]  cmp_row_s1;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  limit_q;
	logic              drain_last;

	assign idle       = (state_q == ST_IDLE);
	assign drain_last = (state_q == ST_DRAIN) && (drain_q == DRN_W'(DRN_N - 1));
	assign load       = drain_last && !out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			row_q      <= '0;
			drain_q    <= '0;
			cmp_en_s1  <= 1'b0;
			cmp_row_s1 <= '0;
		end else begin
			cmp_en_s1  <= (state_q == ST_SCAN);
			cmp_row_s1 <= row_q;
			unique case (state_q)
				ST_IDLE: begin
					row_q   <= '0;
					drain_q <= '0;
					if (start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					row_q <= row_q + 1'b1;
					if (row_q == ROW_W'(SLICE - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// hold on the last count until the output register is free
					if (!drain_last) begin
						drain_q <= drain_q + 1'b1;
					end else if (!out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			addr_q  <= addr;
			limit_q <= (entry_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
			                                                : entry_count;
		end
	end

	always_comb begin
		ctl.clear   = start;
		ctl.rd_en   = (state_q == ST_SCAN);
		ctl.rd_row  = row_q;
		ctl.cmp_en  = cmp_en_s1;
		ctl.cmp_row = cmp_row_s1;
		ctl.addr    = addr_q;
		ctl.limit   = limit_q;
	end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the longest prefix route lookup
// Loads route entries and issues lookups over valid/ready channels. A
// software route table is kept in step with every accepted item, and each
// result is compared field by field with the best match from that table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import lprl_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int SETTLE_CYCLES = SLICE + NCELL + 16;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int FILL_SLOTS    = 192;

	typedef struct packed {
		logic              cmd;
		logic [IDX_W-1:0]  index;
		route_entry_t      entry;
		logic [ADDR_W-1:0] addr;
	} route_req_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] gateway;
		logic [PORT_W-1:0] out_port;
	} route_result_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;

	logic       drv_valid  = 1'b0;
	route_req_t drv_item   = '0;
	logic       sink_ready = 1'b0;

	int send_idle_pct = 18;
	int recv_idle_pct = 82;
	int err_count     = 0;

	route_req_t    req_pending[$];
	route_result_t expected_routes[$];

	// table as the block holds it (updated on acceptance) and as the
	// stimulus side has queued it (updated on generation)
	route_entry_t      route_tbl[TABLE_DEPTH];
	route_entry_t      gen_tbl[TABLE_DEPTH];
	logic [CNT_W-1:0]  entry_count_cfg = '0;
	logic [ADDR_W-1:0] route_bases[4];

	lprl_req_if req_ch ();
	lprl_rsp_if rsp_ch ();

	assign req_ch.valid          = drv_valid;
	assign req_ch.cmd            = drv_item.cmd;
	assign req_ch.entry_index    = drv_item.index;
	assign req_ch.entry_prefix   = drv_item.entry.prefix;
	assign req_ch.entry_mask     = drv_item.entry.mask;
	assign req_ch.entry_gateway  = drv_item.entry.hop;
	assign req_ch.entry_port     = drv_item.entry.port;
	assign req_ch.lookup_addr    = drv_item.addr;
	assign rsp_ch.ready          = sink_ready;

	longest_prefix_route_lookup u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	function automatic int scan_limit();
		return (entry_count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_cfg);
	endfunction

	function automatic route_result_t predict_route(logic [ADDR_W-1:0] addr);
		route_result_t     r;
		logic [ADDR_W-1:0] best_mask;
		r         = '0;
		best_mask = '0;
		for (int i = 0; i < scan_limit(); i++) begin
			if ((addr & route_tbl[i].mask) == route_tbl[i].prefix &&
			    (!r.found || route_tbl[i].mask > best_mask)) begin
				r.found    = 1'b1;
				best_mask  = route_tbl[i].mask;
				r.gateway  = route_tbl[i].hop;
				r.out_port = route_tbl[i].port;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driver, receiver and monitor
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else if (!drv_valid || req_ch.ready) begin
			if (req_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				drv_item  <= req_pending.pop_front();
				drv_valid <= 1'b1;
			end else begin
				drv_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_ready <= 1'b0;
		end else begin
			sink_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : route_monitor
		route_result_t want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				if (req_ch.cmd == CMD_WRITE) begin
					route_tbl[req_ch.entry_index] = '{req_ch.entry_prefix, req_ch.entry_mask,
						req_ch.entry_gateway, req_ch.entry_port};
				end else begin
					expected_routes.push_back(predict_route(req_ch.lookup_addr));
				end
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_routes.size() == 0) begin
					$error("result with no lookup outstanding");
					err_count++;
				end else begin
					want = expected_routes.pop_front();
					if (rsp_ch.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp_ch.found);
						err_count++;
					end
					if (rsp_ch.gateway !== want.gateway) begin
						$error("gateway: expected %h, got %h", want.gateway, rsp_ch.gateway);
						err_count++;
					end
					if (rsp_ch.out_port !== want.out_port) begin
						$error("out_port: expected %0d, got %0d", want.out_port, rsp_ch.out_port);
						err_count++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic push_write(int slot, route_entry_t e);
		route_req_t r;
		r.cmd         = CMD_WRITE;
		r.index       = slot[IDX_W-1:0];
		r.entry       = e;
		r.addr        = $urandom();
		gen_tbl[slot] = e;
		req_pending.push_back(r);
	endtask

	task automatic push_lookup(logic [ADDR_W-1:0] addr);
		route_req_t r;
		r.cmd   = CMD_LOOKUP;
		r.index = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
		r.entry = {$urandom(), $urandom(), $urandom(), 8'($urandom())};
		r.addr  = addr;
		req_pending.push_back(r);
	endtask

	// Mostly prefix routes carved from a few shared bases, so lookups see
	// nested prefixes and equal-mask ties; some odd masks and dead prefixes.
	function automatic route_entry_t random_entry();
		route_entry_t e;
		int           plen;
		int           pick;
		plen     = $urandom_range(0, ADDR_W);
		pick     = $urandom_range(0, 19);
		e.mask   = (plen == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - plen));
		e.prefix = route_bases[$urandom_range(0, 3)] & e.mask;
		if (pick == 0) begin
			e.mask   = $urandom();
			e.prefix = $urandom() & e.mask;
		end else if (pick == 1) begin
			e.prefix = $urandom();
		end
		e.hop  = $urandom();
		e.port = PORT_W'($urandom_range(0, 255));
		return e;
	endfunction

	function automatic logic [ADDR_W-1:0] random_lookup_addr();
		int           pick;
		route_entry_t e;
		pick = $urandom_range(0, 9);
		if (pick < 7 && scan_limit() != 0) begin
			e = gen_tbl[$urandom_range(0, scan_limit() - 1)];
			return (e.prefix & e.mask) | ($urandom() & ~e.mask);
		end
		if (pick < 9) begin
			return route_bases[$urandom_range(0, 3)] ^ ($urandom() >> $urandom_range(4, 31));
		end
		return $urandom();
	endfunction

	task automatic mix_items(int n, int write_pct, int slot_hi);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < write_pct) begin
				push_write(($urandom_range(0, 9) == 0) ? $urandom_range(0, TABLE_DEPTH - 1)
					: $urandom_range(0, slot_hi), random_entry());
			end else begin
				push_lookup(random_lookup_addr());
			end
		end
	endtask

	// Hold until every item is taken and every result is back, then let a
	// trailing write finish inside the block.
	task automatic drain_table();
		while (req_pending.size() != 0 || drv_valid || expected_routes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_entry_count(logic [CNT_W-1:0] n);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we          <= 1'b0;
		entry_count_cfg = n;
		@(negedge clk);
	endtask

	initial begin : watchdog
		int cycles;
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		for (int b = 0; b < 4; b++) route_bases[b] = $urandom();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zero count, nesting, tie, no match, default route
		set_entry_count('0);
		push_lookup(32'h0A01_0203);
		push_write(0, '{32'h0A00_0000, 32'hFF00_0000, 32'h0101_0101, 8'd1});
		push_write(1, '{32'h0A01_0000, 32'hFFFF_0000, 32'h0202_0202, 8'd2});
		push_write(2, '{32'h0A01_0000, 32'hFFFF_0000, 32'h0303_0303, 8'd3});
		push_write(3, '{32'h0A01_0203, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF});
		push_write(4, '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'd0});
		push_write(TABLE_DEPTH - 1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF});
		drain_table();
		set_entry_count(CNT_W'(4));
		push_lookup(32'h0A01_0203);
		push_lookup(32'h0A01_FFFF);
		push_lookup(32'h0AFF_0000);
		push_lookup(32'h0B00_0000);
		push_lookup(32'hFFFF_FFFF);
		push_lookup(32'h0000_0000);
		drain_table();
		set_entry_count(CNT_W'(5));
		push_lookup(32'h0B00_0000);
		push_lookup(32'hFFFF_FFFF);

		// fill the low table while lookups run over the directed entries
		for (int s = 5; s < 64; s++) begin
			push_write(s, random_entry());
			if ($urandom_range(0, 1) == 0) push_lookup(random_lookup_addr());
		end
		drain_table();

		set_entry_count(CNT_W'(64));
		mix_items(60, 40, 63);
		drain_table();
		mix_items(60, 40, 63);
		drain_table();

		send_idle_pct = 82;
		recv_idle_pct = 18;
		set_entry_count(CNT_W'($urandom_range(1, 64)));
		mix_items(120, 35, 63);
		drain_table();
		set_entry_count(CNT_W'(1));
		mix_items(20, 20, 63);
		drain_table();

		// fill more of the table so longer scans reach into the second cell
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int s = 64; s < FILL_SLOTS; s++) begin
			push_write(s, random_entry());
			if ($urandom_range(0, 15) == 0) push_lookup(random_lookup_addr());
		end
		drain_table();

		set_entry_count(CNT_W'(FILL_SLOTS));
		mix_items(40, 40, FILL_SLOTS - 1);
		drain_table();
		set_entry_count(CNT_W'($urandom_range(2, FILL_SLOTS)));
		mix_items(30, 40, FILL_SLOTS - 1);
		drain_table();
		set_entry_count('0);
		mix_items(10, 0, FILL_SLOTS - 1);
		drain_table();

		if (err_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

[longest_prefix_route_lookup.f]
rtl/lprl_pkg.sv
rtl/lprl_if.sv
rtl/lprl_cell.sv
rtl/lprl_ctrl.sv
rtl/longest_prefix_route_lookup.sv
tb/tb_top.sv
